// File: rtl/fat_cluster_allocator_defines.svh
// assertion macros used by the allocator rtl
`ifndef FAT_CLUSTER_ALLOCATOR_DEFINES_SVH
`define FAT_CLUSTER_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS

// check sampled on the rising clock, skipped while reset is high
`define FCA_ASSERT(name, expr) \
   name: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("fca check failed");

// check that also runs across reset
`define FCA_ASSERT_RST(name, expr) \
   name: assert property (@(posedge clock) (expr)) \
      else $error("fca reset check failed");

`else

`define FCA_ASSERT(name, expr)
`define FCA_ASSERT_RST(name, expr)

`endif

`endif

// File: rtl/fca_pkg.sv
// types and constants of the fat cluster allocator
package fca_pkg;

   localparam int LW = 11;
   localparam int XW = 12;
   localparam int LINK_LIMIT = 2049;

   localparam logic [LW-1:0] LINK_FREE     = LW'(0);
   localparam logic [LW-1:0] LINK_END      = LW'(1);
   localparam logic [XW-1:0] FIRST_CLUSTER = XW'(2);
   localparam logic [XW-1:0] WRAP_START    = XW'(3);
   localparam logic [LW-1:0] COUNT_RESET   = LW'(1024);

   typedef enum logic [1:0] {
      MODE_LOAD,
      MODE_ALLOC,
      MODE_FREE,
      MODE_FOLLOW
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK,
      STATUS_NO_FREE,
      STATUS_OUTSIDE
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DISPATCH,
      S_FOLLOW,
      S_SEARCH,
      S_WRAP,
      S_LINK,
      S_LINK_END,
      S_FREE,
      S_COUNT,
      S_DONE
   } state_type;

   typedef struct packed {
      mode_type        mode;
      logic [LW-1:0]   cluster;
      logic [LW-1:0]   value;
   } req_type;

   typedef struct packed {
      logic [LW-1:0]   result_cluster;
      logic [LW-1:0]   freed_count;
      logic [LW-1:0]   free_count;
      status_type      status;
   } rsp_type;

   typedef struct packed {
      logic            wr_en;
      logic [XW-1:0]   wr_addr;
      logic [LW-1:0]   wr_data;
      logic [XW-1:0]   rd_addr;
   } ram_req_type;

endpackage

// File: rtl/fat_cluster_allocator.sv
// fat cluster allocator: link table, request sequencer and free count sweep
// requests: one at a time; req_ready is high only in the idle state, which is entered
//   as the result beat is registered
// reset: a clearing pass writes every one of the DEPTH table entries free with
//   req_ready low; csr writes are taken throughout
`include "fat_cluster_allocator_defines.svh"

module fat_cluster_allocator import fca_pkg::*; #(
   parameter int MAX_CLUSTERS = 1024
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_type         req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_type         rsp_data,
   input  logic            csr_wr_en,
   input  logic [LW-1:0]   csr_wr_data
);

   // entries above 2048, the last cluster of the largest table, are never addressed
   localparam int DEPTH = (MAX_CLUSTERS + 2 > LINK_LIMIT) ? LINK_LIMIT : MAX_CLUSTERS + 2;

   state_type       state_ff, state_in;
   logic [LW-1:0]   table_size_ff, table_size_in;
   req_type         req_ff, req_in;
   logic [XW-1:0]   last_ff, last_in;

   // shared scan unit: pointer, upper bound and one read in flight
   logic [XW-1:0]   ptr_ff, ptr_in;
   logic [XW-1:0]   hi_ff, hi_in;
   logic            pend_ff, pend_in;
   logic [XW-1:0]   pend_addr_ff, pend_addr_in;

   // chain walk and result registers
   logic [XW-1:0]   cur_ff, cur_in;
   logic [XW-1:0]   steps_ff, steps_in;
   logic [XW-1:0]   got_ff, got_in;
   logic [LW-1:0]   res_ff, res_in;
   status_type      status_ff, status_in;
   logic [XW-1:0]   cnt_ff, cnt_in;

   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_data_ff, rsp_data_in;

   ram_req_type     ram_req;
   logic [LW-1:0]   ram_rd_data;

   logic [XW-1:0]   used_w, last_w, clus_w, next_w, steps_nx;
   logic            in_table_w, outside_w;
   logic            issue_w, scan_hit, scan_done;
   logic            free_end_w, free_go_w, free_outside_w;

   fca_link_ram #(
      .DEPTH   (DEPTH)
   ) u_link_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (ram_rd_data)
   );

   // clusters in use: the table size, clamped to MAX_CLUSTERS
   assign used_w = (int'(table_size_ff) > MAX_CLUSTERS) ? XW'(MAX_CLUSTERS)
                                                         : XW'(table_size_ff);
   assign last_w = used_w + XW'(1);

   assign clus_w     = XW'(req_ff.cluster);
   assign in_table_w = (clus_w >= FIRST_CLUSTER) && (clus_w <= last_ff);
   assign outside_w  = clus_w > last_ff;

   // scan unit: issue one read per cycle, test the word read the cycle before
   assign issue_w   = ptr_ff <= hi_ff;
   assign scan_hit  = pend_ff && (ram_rd_data == LINK_FREE);
   assign scan_done = !pend_ff && !issue_w;

   // chain walk: the link of cur_ff is on the read port
   assign next_w         = XW'(ram_rd_data);
   assign steps_nx       = steps_ff + XW'(1);
   assign free_end_w     = ram_rd_data == LINK_FREE;
   assign free_go_w      = (next_w > FIRST_CLUSTER) && (steps_nx <= last_ff)
                           && (next_w <= last_ff);
   assign free_outside_w = (next_w > FIRST_CLUSTER) && (steps_nx <= last_ff)
                           && (next_w > last_ff);

   assign table_size_in = csr_wr_en ? csr_wr_data : table_size_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (ptr_ff == XW'(DEPTH - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) state_in = S_DISPATCH;
         end
         S_DISPATCH: begin
            case (req_ff.mode)
               MODE_LOAD:   state_in = S_COUNT;
               MODE_ALLOC:  state_in = outside_w ? S_COUNT : S_SEARCH;
               MODE_FREE:   state_in = (outside_w || (clus_w <= FIRST_CLUSTER)) ? S_COUNT
                                                                               : S_FREE;
               MODE_FOLLOW: state_in = in_table_w ? S_FOLLOW : S_COUNT;
               default:     state_in = S_COUNT;
            endcase
         end
         S_FOLLOW:   state_in = S_COUNT;
         S_SEARCH: begin
            if (scan_hit) begin
               state_in = S_LINK;
            end else if (scan_done) begin
               state_in = (clus_w > WRAP_START) ? S_WRAP : S_COUNT;
            end
         end
         S_WRAP: begin
            if (scan_hit) begin
               state_in = S_LINK;
            end else if (scan_done) begin
               state_in = S_COUNT;
            end
         end
         S_LINK:     state_in = S_LINK_END;
         S_LINK_END: state_in = S_COUNT;
         S_FREE: begin
            if (free_end_w || !free_go_w) state_in = S_COUNT;
         end
         S_COUNT: begin
            if (scan_done) state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) state_in = S_IDLE;
         end
         default:    state_in = S_CLEAR;
      endcase
   end

   // datapath, memory port and result register
   always_comb begin
      ram_req         = '0;
      ram_req.rd_addr = ptr_ff;
      req_in          = req_ff;
      last_in         = last_ff;
      ptr_in          = ptr_ff;
      hi_in           = hi_ff;
      pend_in         = 1'b0;
      pend_addr_in    = pend_addr_ff;
      cur_in          = cur_ff;
      steps_in        = steps_ff;
      got_in          = got_ff;
      res_in          = res_ff;
      status_in       = status_ff;
      cnt_in          = cnt_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_data_in     = rsp_data_ff;

      unique case (state_ff)
         S_CLEAR: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = ptr_ff;
            ram_req.wr_data = LINK_FREE;
            ptr_in          = ptr_ff + XW'(1);
         end
         S_IDLE: begin
            if (req_valid) begin
               req_in  = req_data;
               last_in = last_w;
            end
         end
         S_DISPATCH: begin
            res_in    = '0;
            steps_in  = '0;
            status_in = STATUS_OK;
            cur_in    = clus_w;
            case (req_ff.mode)
               MODE_LOAD: begin
                  if (in_table_w) begin
                     ram_req.wr_en   = 1'b1;
                     ram_req.wr_addr = clus_w;
                     ram_req.wr_data = req_ff.value;
                  end else begin
                     status_in = STATUS_OUTSIDE;
                  end
               end
               MODE_ALLOC: begin
                  if (outside_w) status_in = STATUS_OUTSIDE;
               end
               MODE_FREE: begin
                  if (outside_w) status_in = STATUS_OUTSIDE;
                  ram_req.rd_addr = clus_w;
               end
               MODE_FOLLOW: begin
                  if (!in_table_w) status_in = STATUS_OUTSIDE;
                  ram_req.rd_addr = clus_w;
               end
               default: ;
            endcase
         end
         S_FOLLOW: begin
            res_in = ram_rd_data;
         end
         S_SEARCH, S_WRAP: begin
            pend_in      = issue_w;
            pend_addr_in = ptr_ff;
            if (issue_w) ptr_in = ptr_ff + XW'(1);
            if (scan_hit) begin
               got_in = pend_addr_ff;
            end else if (scan_done &&
                         !((state_ff == S_SEARCH) && (clus_w > WRAP_START))) begin
               status_in = STATUS_NO_FREE;
            end
         end
         S_LINK: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = got_ff;
            ram_req.wr_data = LINK_END;
            res_in          = got_ff[LW-1:0];
         end
         S_LINK_END: begin
            // no link behind a previous cluster below the table
            if (clus_w >= FIRST_CLUSTER) begin
               ram_req.wr_en   = 1'b1;
               ram_req.wr_addr = clus_w;
               ram_req.wr_data = got_ff[LW-1:0];
            end
         end
         S_FREE: begin
            if (!free_end_w) begin
               ram_req.wr_en   = 1'b1;
               ram_req.wr_addr = cur_ff;
               ram_req.wr_data = LINK_FREE;
               ram_req.rd_addr = next_w;
               steps_in        = steps_nx;
               cur_in          = next_w;
               if (free_outside_w) status_in = STATUS_OUTSIDE;
            end
         end
         S_COUNT: begin
            pend_in      = issue_w;
            pend_addr_in = ptr_ff;
            if (issue_w) ptr_in = ptr_ff + XW'(1);
            if (scan_hit) cnt_in = cnt_ff + XW'(1);
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.result_cluster = res_ff;
               rsp_data_in.freed_count    = steps_ff[LW-1:0];
               rsp_data_in.free_count     = cnt_ff[LW-1:0];
               rsp_data_in.status         = status_ff;
            end
         end
         default: ;
      endcase

      // load the scan unit when a scanning state is entered
      if (state_in != state_ff) begin
         if (state_in == S_COUNT) begin
            ptr_in  = FIRST_CLUSTER;
            hi_in   = last_ff;
            pend_in = 1'b0;
            cnt_in  = '0;
         end
         if (state_in == S_SEARCH) begin
            ptr_in  = (clus_w < FIRST_CLUSTER) ? FIRST_CLUSTER : clus_w + XW'(1);
            hi_in   = last_ff;
            pend_in = 1'b0;
         end
         if (state_in == S_WRAP) begin
            ptr_in  = WRAP_START;
            hi_in   = clus_w - XW'(1);
            pend_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_CLEAR;
         table_size_ff    <= COUNT_RESET;
         ptr_ff           <= '0;
         pend_ff          <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         table_size_ff    <= table_size_in;
         ptr_ff           <= ptr_in;
         pend_ff          <= pend_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      last_ff      <= last_in;
      hi_ff        <= hi_in;
      pend_addr_ff <= pend_addr_in;
      cur_ff       <= cur_in;
      steps_ff     <= steps_in;
      got_ff       <= got_in;
      res_ff       <= res_in;
      status_ff    <= status_in;
      cnt_ff       <= cnt_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // request writes only touch clusters in use
   `FCA_ASSERT(a_wr_in_table, (ram_req.wr_en && (state_ff != S_CLEAR)) |-> ((ram_req.wr_addr >= FIRST_CLUSTER) && (ram_req.wr_addr <= last_ff)))
   // free count can never pass the last cluster in use
   `FCA_ASSERT(a_cnt_bound, (state_ff == S_COUNT) |-> (cnt_ff <= last_ff))
   // the count of cleared links stays below the last cluster in use
   `FCA_ASSERT(a_steps_bound, (state_ff == S_FREE) |-> (steps_ff < last_ff))
   // the result beat is only built after the count sweep
   `FCA_ASSERT(a_done_after_count, ((state_ff == S_DONE) && ($past(state_ff) != S_DONE)) |-> ($past(state_ff) == S_COUNT))
   // reset starts the clearing pass with no beat pending
   `FCA_ASSERT_RST(a_reset_clear, reset |=> ((state_ff == S_CLEAR) && !rsp_valid_ff))

endmodule

// File: rtl/fca_link_ram.sv
// link table memory, one write and one registered write-first read per cycle
module fca_link_ram import fca_pkg::*; #(
   parameter int DEPTH = 1026
) (
   input  logic            clock,
   input  ram_req_type     ram_req,
   output logic [LW-1:0]   rd_data
);

   localparam int AW = $clog2(DEPTH);

   logic [LW-1:0] mem [DEPTH];
   logic [LW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.wr_addr[AW-1:0]] <= ram_req.wr_data;
      end
   end

   // a read of the word being written returns the new value
   always_ff @(posedge clock) begin
      if (ram_req.wr_en && (ram_req.wr_addr == ram_req.rd_addr)) begin
         rd_data_ff <= ram_req.wr_data;
      end else begin
         rd_data_ff <= mem[ram_req.rd_addr[AW-1:0]];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
